/* sv/ppc_pkg.sv */
// Shared types and constants of the PID position controller.
package ppc_pkg;

  // Register indexes on the configuration port
  localparam int CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CFG_GAIN_P       = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_GAIN_I       = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_GAIN_D       = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_WINDOW       = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_SCALE        = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_SINGLE_MOTOR = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_TURN_HEADING = 3'd6;
  localparam int CfgDataW = 31;

  // Operation codes of an input beat
  localparam logic OP_START  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // Register reset values
  localparam logic [15:0] GAIN_P_RST = 16'd256;
  localparam logic [15:0] GAIN_I_RST = 16'd0;
  localparam logic [15:0] GAIN_D_RST = 16'd0;
  localparam logic [30:0] WINDOW_RST = 31'd2560;
  localparam logic [23:0] SCALE_RST  = 24'd2288;

  // Iteration counts of the shared units
  localparam int DivSteps = 32;
  localparam int MulSteps = 16;
  localparam int CntW     = 5;

  // Multiplier operand select
  typedef enum logic [1:0] {
    SEL_P,
    SEL_I,
    SEL_D
  } msel_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic  start;
    logic  capture;
    logic  st_mul;
    logic  st_pos;
    logic  st_err;
    logic  st_diff;
    logic  div_step;
    logic  mul_load;
    msel_t mul_sel;
    logic  mul_step;
    logic  mul_neg;
    logic  out_load;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic active;
  } stat_t;

endpackage

/* sv/ppc_ctrl.sv */
// Sequencer of the PID position controller: handshakes and step control.
module ppc_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           in_operation,
  output logic           out_valid,
  input  logic           out_ready,
  input  ppc_pkg::stat_t stat,
  output ppc_pkg::cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_POS,
    S_ERR,
    S_DIFF,
    S_RUN,
    S_DERIV,
    S_DMUL,
    S_OUT
  } state_t;

  state_t                     state_r, state_nxt;
  logic [ppc_pkg::CntW-1:0]   cnt_r, cnt_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic                       in_acc;

  localparam logic [ppc_pkg::CntW-1:0] RunLast  = ppc_pkg::CntW'(ppc_pkg::DivSteps - 1);
  localparam logic [ppc_pkg::CntW-1:0] MulLast  = ppc_pkg::CntW'(ppc_pkg::MulSteps - 1);

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd.start   = in_acc && (in_operation == ppc_pkg::OP_START);
    cmd.capture = in_acc && (in_operation == ppc_pkg::OP_SAMPLE) && stat.active;
    case (state_r)
      S_IDLE: begin
        if (cmd.capture) state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.st_mul = 1'b1;
        state_nxt  = S_POS;
      end
      S_POS: begin
        cmd.st_pos = 1'b1;
        state_nxt  = S_ERR;
      end
      S_ERR: begin
        cmd.st_err = 1'b1;
        state_nxt  = S_DIFF;
      end
      S_DIFF: begin
        cmd.st_diff  = 1'b1;
        cmd.mul_load = 1'b1;
        cmd.mul_sel  = ppc_pkg::SEL_P;
        cnt_nxt      = '0;
        state_nxt    = S_RUN;
      end
      S_RUN: begin
        // divider and the P then I products run side by side
        cmd.div_step = 1'b1;
        cmd.mul_step = 1'b1;
        cmd.mul_neg  = (cnt_r[3:0] == MulLast[3:0]);
        if (cnt_r == MulLast) begin
          cmd.mul_load = 1'b1;
          cmd.mul_sel  = ppc_pkg::SEL_I;
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == RunLast) state_nxt = S_DERIV;
      end
      S_DERIV: begin
        cmd.mul_load = 1'b1;
        cmd.mul_sel  = ppc_pkg::SEL_D;
        cnt_nxt      = '0;
        state_nxt    = S_DMUL;
      end
      S_DMUL: begin
        cmd.mul_step = 1'b1;
        cmd.mul_neg  = (cnt_r == MulLast);
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == MulLast) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* sv/ppc_datapath.sv */
// Datapath of the PID position controller: registers, position, divider, shift-add multiplier.
module ppc_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [ppc_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [ppc_pkg::CfgDataW-1:0]  cfg_wdata,
  input  logic [31:0]                   in_target,
  input  logic                          in_turn_mode,
  input  logic                          in_direction_reverse,
  input  logic                          in_zero_sensors,
  input  logic [23:0]                   in_encoder_left,
  input  logic [23:0]                   in_encoder_right,
  input  logic [31:0]                   in_heading,
  input  logic [31:0]                   in_time_ms,
  input  ppc_pkg::cmd_t                 cmd,
  output ppc_pkg::stat_t                stat,
  output logic [15:0]                   out_drive_left,
  output logic [15:0]                   out_drive_right,
  output logic                          out_drive_reverse,
  output logic                          out_move_done,
  output logic                          out_zero_request
);

  localparam int AccW = 66;

  // configuration
  logic [15:0] gain_p_r, gain_i_r, gain_d_r;
  logic [30:0] window_r;
  logic [23:0] scale_r;
  logic        single_r, turn_head_r;

  // loop state
  logic        active_r;
  logic [31:0] goal_r;
  logic        mode_turn_r, dir_r;
  logic [47:0] esum_r;
  logic [31:0] last_err_r, last_time_r;
  logic        have_last_r;

  // captured sample
  logic        zero_r;
  logic [23:0] left_r, right_r;
  logic [31:0] heading_r, time_r;

  // working registers
  logic signed [49:0] prod_r;
  logic [31:0]        pos_r, err_r, dt_r;
  logic               done_r, dz_r, dneg_r;
  logic [32:0]        rem_r;
  logic [31:0]        quo_r;
  logic [AccW-1:0]    mcand_r, acc_r;
  logic [15:0]        mplier_r;

  // output register
  logic [15:0] out_left_r, out_right_r;
  logic        out_rev_r, out_done_r, out_zero_r;

  logic signed [24:0] sum_lr, scale_s;
  logic [31:0]        pos_avg, pos_nxt, err_nxt;
  logic [32:0]        gdiff, pos_mag, goal_mag, err_mag, ddiff, ddiff_mag;
  logic [48:0]        esum_sum;
  logic [47:0]        esum_nxt;
  logic               in_window;
  logic [32:0]        div_sh, div_sub;
  logic               div_ge;
  logic [32:0]        deriv;
  logic [AccW-1:0]    operand;
  logic [15:0]        gain_sel;
  logic               sat16_ok;
  logic [15:0]        pl, pr;

  assign stat.active = active_r;

  // position
  assign sum_lr  = $signed({left_r[23], left_r}) + $signed({right_r[23], right_r});
  assign scale_s = $signed({1'b0, scale_r});

  always_comb begin
    if (prod_r[49:40] == {10{prod_r[40]}}) pos_avg = prod_r[40:9];
    else pos_avg = prod_r[49] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    if (zero_r) pos_nxt = '0;
    else if (mode_turn_r) pos_nxt = turn_head_r ? heading_r : {sum_lr, 7'b0};
    else if (single_r) pos_nxt = {left_r, 8'b0};
    else pos_nxt = pos_avg;
  end

  // error and completion
  always_comb begin
    gdiff = {goal_r[31], goal_r} - {pos_r[31], pos_r};
    if (gdiff[32] != gdiff[31]) err_nxt = gdiff[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    else err_nxt = gdiff[31:0];
    pos_mag  = pos_r[31] ? (33'd0 - {1'b1, pos_r}) : {1'b0, pos_r};
    goal_mag = goal_r[31] ? (33'd0 - {1'b1, goal_r}) : {1'b0, goal_r};
  end

  // windowed integral
  always_comb begin
    err_mag   = err_r[31] ? (33'd0 - {1'b1, err_r}) : {1'b0, err_r};
    in_window = err_mag < {2'b0, window_r};
    esum_sum  = {esum_r[47], esum_r} + {{17{err_r[31]}}, err_r};
    if (!in_window) esum_nxt = '0;
    else if (esum_sum[48] != esum_sum[47])
      esum_nxt = esum_sum[48] ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
    else esum_nxt = esum_sum[47:0];
    ddiff     = {err_r[31], err_r} - {last_err_r[31], last_err_r};
    ddiff_mag = ddiff[32] ? (33'd0 - ddiff) : ddiff;
  end

  // restoring divider, one quotient bit a beat of the step command
  always_comb begin
    div_sh  = {rem_r[31:0], quo_r[31]};
    div_ge  = div_sh >= {1'b0, dt_r};
    div_sub = div_sh - {1'b0, dt_r};
    if (dz_r) deriv = '0;
    else deriv = dneg_r ? (33'd0 - {1'b0, quo_r}) : {1'b0, quo_r};
  end

  // multiplier operand
  always_comb begin
    case (cmd.mul_sel)
      ppc_pkg::SEL_P: begin
        operand  = {{(AccW-32){err_r[31]}}, err_r};
        gain_sel = gain_p_r;
      end
      ppc_pkg::SEL_I: begin
        operand  = {{(AccW-48){esum_r[47]}}, esum_r};
        gain_sel = gain_i_r;
      end
      ppc_pkg::SEL_D: begin
        operand  = {{(AccW-33){deriv[32]}}, deriv};
        gain_sel = gain_d_r;
      end
      default: begin
        operand  = '0;
        gain_sel = '0;
      end
    endcase
  end

  // output saturation
  always_comb begin
    sat16_ok = (&acc_r[AccW-1:23]) || !(|acc_r[AccW-1:23]);
    if (sat16_ok) pl = acc_r[23:8];
    else pl = acc_r[AccW-1] ? 16'h8000 : 16'h7FFF;
    if (!mode_turn_r) pr = pl;
    else if (pl == 16'h8000) pr = 16'h7FFF;
    else pr = 16'd0 - pl;
  end

  // configuration and loop state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r    <= ppc_pkg::GAIN_P_RST;
      gain_i_r    <= ppc_pkg::GAIN_I_RST;
      gain_d_r    <= ppc_pkg::GAIN_D_RST;
      window_r    <= ppc_pkg::WINDOW_RST;
      scale_r     <= ppc_pkg::SCALE_RST;
      single_r    <= 1'b0;
      turn_head_r <= 1'b0;
      active_r    <= 1'b0;
      goal_r      <= '0;
      mode_turn_r <= 1'b0;
      dir_r       <= 1'b0;
      esum_r      <= '0;
      last_err_r  <= '0;
      last_time_r <= '0;
      have_last_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          ppc_pkg::CFG_GAIN_P:       gain_p_r    <= cfg_wdata[15:0];
          ppc_pkg::CFG_GAIN_I:       gain_i_r    <= cfg_wdata[15:0];
          ppc_pkg::CFG_GAIN_D:       gain_d_r    <= cfg_wdata[15:0];
          ppc_pkg::CFG_WINDOW:       window_r    <= cfg_wdata[30:0];
          ppc_pkg::CFG_SCALE:        scale_r     <= cfg_wdata[23:0];
          ppc_pkg::CFG_SINGLE_MOTOR: single_r    <= cfg_wdata[0];
          ppc_pkg::CFG_TURN_HEADING: turn_head_r <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (cmd.start) begin
        goal_r      <= in_target;
        mode_turn_r <= in_turn_mode;
        dir_r       <= in_direction_reverse;
        esum_r      <= '0;
        last_err_r  <= '0;
        have_last_r <= 1'b0;
        active_r    <= 1'b1;
      end
      if (cmd.st_diff) begin
        esum_r      <= esum_nxt;
        last_err_r  <= err_r;
        last_time_r <= time_r;
        have_last_r <= 1'b1;
        if (done_r) active_r <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      zero_r    <= in_zero_sensors;
      left_r    <= in_encoder_left;
      right_r   <= in_encoder_right;
      heading_r <= in_heading;
      time_r    <= in_time_ms;
    end
    if (cmd.st_mul) prod_r <= sum_lr * scale_s;
    if (cmd.st_pos) pos_r <= pos_nxt;
    if (cmd.st_err) begin
      err_r  <= err_nxt;
      done_r <= pos_mag >= goal_mag;
    end
    if (cmd.st_diff) begin
      dz_r   <= !have_last_r || (time_r == last_time_r);
      dt_r   <= time_r - last_time_r;
      dneg_r <= ddiff[32];
      quo_r  <= ddiff_mag[31:0];
      rem_r  <= '0;
      acc_r  <= '0;
    end else if (cmd.div_step) begin
      rem_r <= div_ge ? div_sub : div_sh;
      quo_r <= {quo_r[30:0], div_ge};
    end
    if (cmd.mul_step && mplier_r[0] && !cmd.st_diff) begin
      // top gain bit carries negative weight
      acc_r <= cmd.mul_neg ? (acc_r - mcand_r) : (acc_r + mcand_r);
    end
    if (cmd.mul_load) begin
      mcand_r  <= operand;
      mplier_r <= gain_sel;
    end else if (cmd.mul_step) begin
      mcand_r  <= {mcand_r[AccW-2:0], 1'b0};
      mplier_r <= {1'b0, mplier_r[15:1]};
    end
    if (cmd.out_load) begin
      out_left_r  <= pl;
      out_right_r <= pr;
      out_rev_r   <= dir_r;
      out_done_r  <= done_r;
      out_zero_r  <= zero_r;
    end
  end

  assign out_drive_left    = out_left_r;
  assign out_drive_right   = out_right_r;
  assign out_drive_reverse = out_rev_r;
  assign out_move_done     = out_done_r;
  assign out_zero_request  = out_zero_r;

endmodule

/* sv/pid_position_controller_unit.sv */
// Top level of the PID position controller with integral window.
//
//  channel | direction | handshake            | beat
//  in_     | input     | in_valid / in_ready   | start command or control sample
//  out_    | output    | out_valid / out_ready | drive command, one per active sample
//  cfg_    | input     | cfg_we                | register write, index cfg_index
//
// A start beat leaves the sequencer idle. A sample beat passes from acceptance to
// the result register through the 32-step restoring divider for the derivative,
// followed by the 16-step shift-add multiplier for the derivative term.
// Reset is synchronous and active low and restores register defaults and loop state.
// A waiting result does not block the next beat; only a finished sample whose
// predecessor is still unread waits in its last step for out_ready.
module pid_position_controller_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [ppc_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [ppc_pkg::CfgDataW-1:0]  cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_operation,
  input  logic [31:0]                   in_target,
  input  logic                          in_turn_mode,
  input  logic                          in_direction_reverse,
  input  logic                          in_zero_sensors,
  input  logic [23:0]                   in_encoder_left,
  input  logic [23:0]                   in_encoder_right,
  input  logic [31:0]                   in_heading,
  input  logic [31:0]                   in_time_ms,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [15:0]                   out_drive_left,
  output logic [15:0]                   out_drive_right,
  output logic                          out_drive_reverse,
  output logic                          out_move_done,
  output logic                          out_zero_request
);

  ppc_pkg::cmd_t  cmd;
  ppc_pkg::stat_t stat;

  ppc_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operation (in_operation),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .stat         (stat),
    .cmd          (cmd)
  );

  ppc_datapath u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_target            (in_target),
    .in_turn_mode         (in_turn_mode),
    .in_direction_reverse (in_direction_reverse),
    .in_zero_sensors      (in_zero_sensors),
    .in_encoder_left      (in_encoder_left),
    .in_encoder_right     (in_encoder_right),
    .in_heading           (in_heading),
    .in_time_ms           (in_time_ms),
    .cmd                  (cmd),
    .stat                 (stat),
    .out_drive_left       (out_drive_left),
    .out_drive_right      (out_drive_right),
    .out_drive_reverse    (out_drive_reverse),
    .out_move_done        (out_move_done),
    .out_zero_request     (out_zero_request)
  );

endmodule
